### design/ofb_pkg.sv
// ============================================================================
// ofb_pkg
// Shared types, command codes, font table and set-up stream bytes for the
// page-mode text framebuffer.
// ============================================================================
package ofb_pkg;

    localparam int FB_WIDTH   = 128;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_PIXEL  = 3'd1;
    localparam logic [2:0] CMD_TEXT   = 3'd2;
    localparam logic [2:0] CMD_WINDOW = 3'd3;
    localparam logic [2:0] CMD_CHUNK  = 3'd4;
    localparam logic [2:0] CMD_INIT   = 3'd5;

    localparam logic [1:0] REG_ROWS64   = 2'd0;
    localparam logic [1:0] REG_CONTRAST = 2'd1;
    localparam logic [1:0] REG_ROTATE   = 2'd2;
    localparam logic [1:0] REG_INVERT   = 2'd3;

    localparam logic [4:0] INIT_LAST_IDX   = 5'd26;
    localparam logic [4:0] WINDOW_LAST_IDX = 5'd6;
    localparam logic [7:0] DATA_HEADER     = 8'h40;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       pixel_on;
        logic [7:0] char_code;
        logic       text_start;
        logic [5:0] chunk_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       stream_last;
    } out_item_t;

    typedef struct packed {
        logic       rows_64;
        logic [7:0] contrast;
        logic       rotate;
        logic       invert;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_EMIT,
        ST_CHUNK_HDR,
        ST_CHUNK_RD,
        ST_CHUNK_EMIT
    } state_t;

    typedef enum logic {
        SK_INIT,
        SK_WINDOW
    } stream_kind_t;

    typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;

    // Font lookup; unknown codes fall back to the question mark glyph
    function automatic glyph_t glyph_cols(input logic [7:0] code);
        glyph_t g;
        case (code)
            8'h20: g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            8'h2E: g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
            8'h3A: g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
            8'h30: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
            8'h31: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
            8'h32: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
            8'h33: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
            8'h34: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
            8'h35: g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
            8'h36: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
            8'h37: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
            8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
            8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'h42: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
            8'h43: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h44: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
            8'h45: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
            8'h46: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
            8'h47: g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
            8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'h4A: g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
            8'h4B: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
            8'h4C: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
            8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'h4E: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
            8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h50: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
            8'h51: g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
            8'h52: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
            8'h53: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
            8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'h57: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'h5A: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
            default: g = {8'h06, 8'h09, 8'h59, 8'h01, 8'h02};
        endcase
        return g;
    endfunction

    // Byte idx of the init or window stream
    function automatic logic [7:0] stream_byte(
        input stream_kind_t kind,
        input logic [4:0]   idx,
        input cfg_t         cfg,
        input logic [7:0]   rows_m1,
        input logic [7:0]   pages_m1,
        input logic         rows_is_64
    );
        logic [7:0] b;
        b = 8'h00;
        if (kind == SK_WINDOW)
        begin
            case (idx)
                5'd1:    b = 8'h21;
                5'd3:    b = 8'(FB_WIDTH - 1);
                5'd4:    b = 8'h22;
                5'd6:    b = pages_m1;
                default: b = 8'h00;
            endcase
        end
        else
        begin
            case (idx)
                5'd1:    b = 8'hAE;
                5'd2:    b = 8'hD5;
                5'd3:    b = 8'h80;
                5'd4:    b = 8'hA8;
                5'd5:    b = rows_m1;
                5'd6:    b = 8'hD3;
                5'd8:    b = 8'h40;
                5'd9:    b = 8'h8D;
                5'd10:   b = 8'h14;
                5'd11:   b = 8'h20;
                5'd13:   b = cfg.rotate ? 8'hA0 : 8'hA1;
                5'd14:   b = cfg.rotate ? 8'hC0 : 8'hC8;
                5'd15:   b = 8'hDA;
                5'd16:   b = rows_is_64 ? 8'h12 : 8'h02;
                5'd17:   b = 8'h81;
                5'd18:   b = cfg.contrast;
                5'd19:   b = 8'hD9;
                5'd20:   b = 8'hF1;
                5'd21:   b = 8'hDB;
                5'd22:   b = 8'h40;
                5'd23:   b = 8'hA4;
                5'd24:   b = cfg.invert ? 8'hA7 : 8'hA6;
                5'd25:   b = 8'h2E;
                5'd26:   b = 8'hAF;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

### design/oled_text_framebuffer.sv
// A pixel is read from the store and written back (ST_PIX_RD, ST_PIX_WR); a
// glyph does so for each pixel of its 5x7 cell. Window and init bytes are
// emitted byte by byte; a chunk sends a header, then reads and emits each store
// byte. Clear and init sweep all FB_WIDTH*FB_MAX_ROWS/8 store entries (1024 by
// default) one entry per cycle, set by the single write port of the store RAM.
// One command is in flight at a time; each output byte waits in the output
// register until taken. After reset the same clearing sweep runs and in_ready stays low until it ends.
// ============================================================================
// oled_text_framebuffer
// Page-organized monochrome framebuffer with 5x7 text drawing and panel
// set-up, window and data chunk byte streams.
// ============================================================================
module oled_text_framebuffer #(
    parameter int FB_MAX_ROWS = 64,
    parameter int CHUNK_BYTES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ofb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ofb_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ofb_pkg::*;

    localparam int STORE_DEPTH = FB_WIDTH * FB_MAX_ROWS / 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PAGE_W      = ADDR_W - 7;
    localparam int LEN_W       = $clog2(CHUNK_BYTES + 1);
    localparam int OFF_W       = 12;

    cfg_t cfg;

    // Store RAM port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Control and datapath registers
    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              set_ready_reg, set_ready_next;
    logic              panel_ready_reg, panel_ready_next;
    logic [7:0]        cursor_reg, cursor_next;
    logic              stopped_reg, stopped_next;
    logic [7:0]        px_x_reg, px_x_next;
    logic [7:0]        px_y_reg, px_y_next;
    logic              px_on_reg, px_on_next;
    logic              glyph_mode_reg, glyph_mode_next;
    glyph_t            glyph_reg, glyph_next;
    logic [2:0]        gc_reg, gc_next;
    logic [2:0]        gr_reg, gr_next;
    logic              pw_valid_reg, pw_valid_next;
    logic [ADDR_W-1:0] pw_addr_reg, pw_addr_next;
    logic [7:0]        pw_mask_reg, pw_mask_next;
    logic              pw_on_reg, pw_on_next;
    stream_kind_t      kind_reg, kind_next;
    logic [4:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0] ch_addr_reg, ch_addr_next;
    logic [LEN_W-1:0]  ch_cnt_reg, ch_cnt_next;
    logic [LEN_W-1:0]  ch_len_reg, ch_len_next;

    // Derived values
    logic [6:0]       rows;
    logic [OFF_W-1:0] total;
    logic [OFF_W-1:0] chunk_off;
    logic [OFF_W-1:0] chunk_rem;
    logic             slot_free;
    logic             in_fire;
    logic [7:0]       cur_x, cur_y;
    logic             cur_on;
    logic             cur_in;
    logic [7:0]       cur_eff;
    logic             stop_eff;
    logic             emit_last;

    ofb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ofb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rows      = cfg.rows_64 ? 7'(FB_MAX_ROWS) : 7'd32;
    assign total     = OFF_W'(rows) << 4;
    assign chunk_off = OFF_W'(in_data.chunk_index) * OFF_W'(CHUNK_BYTES);
    assign chunk_rem = total - chunk_off;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cur_eff   = in_data.text_start ? in_data.x_pos : cursor_reg;
    assign stop_eff  = in_data.text_start ? 1'b0 : stopped_reg;
    assign emit_last = (kind_reg == SK_INIT) ? (idx_reg == INIT_LAST_IDX)
                                             : (idx_reg == WINDOW_LAST_IDX);

    // Current pixel of a pixel or glyph operation, with clipping
    always_comb
    begin
        if (glyph_mode_reg)
        begin
            cur_x  = px_x_reg + 8'(gc_reg);
            cur_y  = px_y_reg + 8'(gr_reg);
            cur_on = glyph_reg[gc_reg][gr_reg];
        end
        else
        begin
            cur_x  = px_x_reg;
            cur_y  = px_y_reg;
            cur_on = px_on_reg;
        end
        cur_in = !cur_x[7] && (cur_y < {1'b0, rows});
    end

    // Sequencer: next state, store access and output register load
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        clr_cnt_next     = clr_cnt_reg;
        set_ready_next   = set_ready_reg;
        panel_ready_next = panel_ready_reg;
        cursor_next      = cursor_reg;
        stopped_next     = stopped_reg;
        px_x_next        = px_x_reg;
        px_y_next        = px_y_reg;
        px_on_next       = px_on_reg;
        glyph_mode_next  = glyph_mode_reg;
        glyph_next       = glyph_reg;
        gc_next          = gc_reg;
        gr_next          = gr_reg;
        pw_valid_next    = pw_valid_reg;
        pw_addr_next     = pw_addr_reg;
        pw_mask_next     = pw_mask_reg;
        pw_on_next       = pw_on_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        ch_addr_next     = ch_addr_reg;
        ch_cnt_next      = ch_cnt_reg;
        ch_len_next      = ch_len_reg;
        ram_we           = 1'b0;
        ram_waddr        = pw_addr_reg;
        ram_wdata        = 8'h00;
        ram_re           = 1'b0;
        ram_raddr        = ch_addr_reg;

        // Drop the output transaction once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                    if (set_ready_reg)
                    begin
                        panel_ready_next = 1'b1;
                        set_ready_next   = 1'b0;
                    end
                end
            end

            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.command)
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        CMD_PIXEL:
                        begin
                            px_x_next       = in_data.x_pos;
                            px_y_next       = in_data.y_pos;
                            px_on_next      = in_data.pixel_on;
                            glyph_mode_next = 1'b0;
                            state_next      = ST_PIX_RD;
                        end
                        CMD_TEXT:
                        begin
                            cursor_next  = cur_eff;
                            stopped_next = stop_eff;
                            if (!stop_eff)
                            begin
                                if ({1'b0, cur_eff} + 9'd5 > 9'(FB_WIDTH))
                                begin
                                    stopped_next = 1'b1;
                                end
                                else
                                begin
                                    cursor_next     = cur_eff + 8'd6;
                                    px_x_next       = cur_eff;
                                    px_y_next       = in_data.y_pos;
                                    glyph_next      = glyph_cols(in_data.char_code);
                                    glyph_mode_next = 1'b1;
                                    gc_next         = '0;
                                    gr_next         = '0;
                                    state_next      = ST_PIX_RD;
                                end
                            end
                        end
                        CMD_WINDOW:
                        begin
                            if (panel_ready_reg)
                            begin
                                kind_next  = SK_WINDOW;
                                idx_next   = '0;
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_CHUNK:
                        begin
                            if (panel_ready_reg && (chunk_off < total))
                            begin
                                ch_addr_next = chunk_off[ADDR_W-1:0];
                                ch_cnt_next  = '0;
                                if (chunk_rem > OFF_W'(CHUNK_BYTES))
                                begin
                                    ch_len_next = LEN_W'(CHUNK_BYTES);
                                end
                                else
                                begin
                                    ch_len_next = chunk_rem[LEN_W-1:0];
                                end
                                state_next = ST_CHUNK_HDR;
                            end
                        end
                        CMD_INIT:
                        begin
                            kind_next  = SK_INIT;
                            idx_next   = '0;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PIX_RD:
            begin
                // Issue the read of the byte that holds this pixel
                ram_re        = 1'b1;
                ram_raddr     = {cur_y[3 +: PAGE_W], cur_x[6:0]};
                pw_addr_next  = {cur_y[3 +: PAGE_W], cur_x[6:0]};
                pw_mask_next  = 8'(1) << cur_y[2:0];
                pw_on_next    = cur_on;
                pw_valid_next = cur_in;
                state_next    = ST_PIX_WR;
            end

            ST_PIX_WR:
            begin
                // Modify and write back
                ram_we    = pw_valid_reg;
                ram_waddr = pw_addr_reg;
                ram_wdata = pw_on_reg ? (ram_rdata | pw_mask_reg)
                                      : (ram_rdata & ~pw_mask_reg);
                state_next = ST_IDLE;
                if (glyph_mode_reg)
                begin
                    if (gr_reg == 3'(GLYPH_ROWS - 1))
                    begin
                        gr_next = '0;
                        gc_next = gc_reg + 1'b1;
                        if (gc_reg != 3'(GLYPH_COLS - 1))
                        begin
                            state_next = ST_PIX_RD;
                        end
                    end
                    else
                    begin
                        gr_next    = gr_reg + 1'b1;
                        state_next = ST_PIX_RD;
                    end
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.out_byte = stream_byte(kind_reg, idx_reg, cfg,
                                                         8'(rows) - 8'd1,
                                                         8'(rows >> 3) - 8'd1,
                                                         rows == 7'd64);
                    out_data_next.stream_last = emit_last;
                    idx_next = idx_reg + 1'b1;
                    if (emit_last)
                    begin
                        if (kind_reg == SK_INIT)
                        begin
                            set_ready_next = 1'b1;
                            clr_cnt_next   = '0;
                            state_next     = ST_CLEAR;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_CHUNK_HDR:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.out_byte    = DATA_HEADER;
                    out_data_next.stream_last = 1'b0;
                    state_next                = ST_CHUNK_RD;
                end
            end

            ST_CHUNK_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ch_addr_reg;
                state_next = ST_CHUNK_EMIT;
            end

            ST_CHUNK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.out_byte    = ram_rdata;
                    out_data_next.stream_last = (ch_cnt_reg == ch_len_reg - 1'b1);
                    ch_cnt_next               = ch_cnt_reg + 1'b1;
                    ch_addr_next              = ch_addr_reg + 1'b1;
                    state_next = (ch_cnt_reg == ch_len_reg - 1'b1) ? ST_IDLE : ST_CHUNK_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            out_valid_reg   <= 1'b0;
            clr_cnt_reg     <= '0;
            set_ready_reg   <= 1'b0;
            panel_ready_reg <= 1'b0;
            cursor_reg      <= '0;
            stopped_reg     <= 1'b0;
            glyph_mode_reg  <= 1'b0;
            gc_reg          <= '0;
            gr_reg          <= '0;
            pw_valid_reg    <= 1'b0;
            kind_reg        <= SK_INIT;
            idx_reg         <= '0;
            ch_cnt_reg      <= '0;
            ch_len_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            clr_cnt_reg     <= clr_cnt_next;
            set_ready_reg   <= set_ready_next;
            panel_ready_reg <= panel_ready_next;
            cursor_reg      <= cursor_next;
            stopped_reg     <= stopped_next;
            glyph_mode_reg  <= glyph_mode_next;
            gc_reg          <= gc_next;
            gr_reg          <= gr_next;
            pw_valid_reg    <= pw_valid_next;
            kind_reg        <= kind_next;
            idx_reg         <= idx_next;
            ch_cnt_reg      <= ch_cnt_next;
            ch_len_reg      <= ch_len_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        px_x_reg     <= px_x_next;
        px_y_reg     <= px_y_next;
        px_on_reg    <= px_on_next;
        glyph_reg    <= glyph_next;
        pw_addr_reg  <= pw_addr_next;
        pw_mask_reg  <= pw_mask_next;
        pw_on_reg    <= pw_on_next;
        ch_addr_reg  <= ch_addr_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/ofb_ram.sv
// ============================================================================
// ofb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module ofb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ofb_cfg.sv
// ============================================================================
// ofb_cfg
// APB register file for panel configuration.
// ============================================================================
module ofb_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ofb_pkg::cfg_t     cfg
);
    import ofb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ROWS64:   cfg_next.rows_64  = pwdata[0];
                REG_CONTRAST: cfg_next.contrast = pwdata[7:0];
                REG_ROTATE:   cfg_next.rotate   = pwdata[0];
                REG_INVERT:   cfg_next.invert   = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{rows_64: 1'b1, contrast: 8'd127, rotate: 1'b0, invert: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_ROWS64:   prdata = {31'd0, cfg_reg.rows_64};
            REG_CONTRAST: prdata = {24'd0, cfg_reg.contrast};
            REG_ROTATE:   prdata = {31'd0, cfg_reg.rotate};
            REG_INVERT:   prdata = {31'd0, cfg_reg.invert};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/ofb_checker.sv
// ============================================================================
// ofb_checker
// Port-level checks on the framebuffer handshakes and stream framing.
// ============================================================================
module ofb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input ofb_pkg::out_item_t out_data,
    input logic               pready
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction dropped or changed while stalled");

    // No new command while a stream is only partly delivered
    a_mid_stream: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.stream_last |-> !in_ready)
        else $error("command accepted in the middle of a stream");

    // A non-final byte is followed by more of the same stream
    a_stream_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.stream_last |=> !in_ready || out_valid)
        else $error("stream ended without a final byte");

    // Configuration port never stalls
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind oled_text_framebuffer ofb_checker u_ofb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);
